// File: sv/jfhp_pkg.sv
// Shared definitions for the JPEG frame header probe: marker codes, status
// codes, register indexes and the frame-marker test.
// No dependencies.
package jfhp_pkg;

   // Marker bytes.
   localparam logic [7:0] MARKER_PREFIX = 8'hFF;
   localparam logic [7:0] MARKER_SOI    = 8'hD8;
   localparam logic [7:0] MARKER_TEM    = 8'h01;
   localparam logic [7:0] MARKER_RST_LO = 8'hD0;
   localparam logic [7:0] MARKER_RST_HI = 8'hD9;
   localparam logic [7:0] MARKER_SOF_LO = 8'hC0;
   localparam logic [7:0] MARKER_SOF_HI = 8'hCF;
   localparam logic [7:0] MARKER_DHT    = 8'hC4;
   localparam logic [7:0] MARKER_JPG    = 8'hC8;
   localparam logic [7:0] MARKER_DAC    = 8'hCC;
   localparam logic [7:0] MARKER_SOF2   = 8'hC2;
   localparam logic [7:0] MARKER_SOS    = 8'hDA;

   // Result status codes; STATUS_NONE means no result for this byte.
   typedef logic [2:0] status_type;
   localparam status_type STATUS_OK    = 3'd0;
   localparam status_type STATUS_SHORT = 3'd1;
   localparam status_type STATUS_NOHDR = 3'd2;
   localparam status_type STATUS_PROG  = 3'd3;
   localparam status_type STATUS_BIG   = 3'd4;
   localparam status_type STATUS_NONE  = 3'd7;

   // Configuration register indexes.
   typedef logic [0:0] csr_index_type;
   localparam csr_index_type CSR_MAX_WIDTH  = 1'b0;
   localparam csr_index_type CSR_MAX_HEIGHT = 1'b1;

   localparam logic [15:0] MAX_WIDTH_RESET  = 16'd1024;
   localparam logic [15:0] MAX_HEIGHT_RESET = 16'd1024;

   // Minimum segment lengths and the byte count below which a stream is short.
   localparam logic [15:0] SEG_LEN_MIN = 16'd2;
   localparam logic [15:0] SOF_LEN_MIN = 16'd8;
   localparam logic [2:0]  SHORT_LIMIT = 3'd4;

   // SOF markers are C0..CF except DHT, JPG and DAC.
   function automatic logic is_frame_marker(input logic [7:0] m);
      return (m >= MARKER_SOF_LO) && (m <= MARKER_SOF_HI) &&
             (m != MARKER_DHT) && (m != MARKER_JPG) && (m != MARKER_DAC);
   endfunction

   // Progressive frames: C2, C6, CA and CE share the low two bits 10.
   function automatic logic is_progressive(input logic [7:0] m);
      return (m[7:4] == MARKER_SOF2[7:4]) && (m[1:0] == MARKER_SOF2[1:0]);
   endfunction

endpackage

// File: sv/jpeg_frame_header_probe.sv
// JPEG frame header probe: byte-wise marker parser that reports the first
// frame header's size and a status per stream.
// Depends on jfhp_pkg.
//
// Usage: a JPEG file enters one byte per transfer on the req_ channel, with
// req_last_byte set on its final byte. The block walks the marker structure
// (SOI check, fill bytes, standalone markers, length-counted segments) and
// gives exactly one transfer on the rsp_ channel per stream: a status and,
// when the status is ok, the width and height of the first frame header.
// Bytes after that result are dropped until the final byte of the stream,
// after which the parser starts over for the next file.
// Timing: one byte per cycle while the result register is not stalled. A byte
// is held in an input register and parsed from there; the result register is
// loaded at the edge that consumes that byte.
// Stall: while the result register is full and rsp_stall is high, the parser
// holds its byte and req_stall rises; no byte or result is lost.
// Reset (synchronous, active high) clears both channels, restores the parser
// to expect a start of image, and sets both size limits to 1024.
// The csr_ channel is always ready; index 0 writes max_width, index 1
// max_height. Write them only while no stream is in flight.
module jpeg_frame_header_probe
   import jfhp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [7:0]    req_data_byte,
   input  logic          req_last_byte,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [2:0]    rsp_status,
   output logic [15:0]   rsp_width,
   output logic [15:0]   rsp_height,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  logic [15:0]   csr_wdata
);

   typedef enum logic [3:0] {
      PH_SOI0, PH_SOI1, PH_SCAN, PH_MARK, PH_LENH, PH_LENL, PH_BODY, PH_PEND,
      PH_IGNORE
   } phase_type;

   // Configuration registers.
   logic [15:0] max_width_ff, max_height_ff;

   // Input register.
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;

   // Parser state.
   phase_type   phase_ff, phase_in;
   logic [2:0]  bytes_seen_ff, bytes_seen_in;
   logic [7:0]  marker_ff, marker_in;
   logic [15:0] seg_len_ff, seg_len_in;
   logic [15:0] seg_off_ff, seg_off_in;
   logic [15:0] frame_h_ff, frame_h_in;
   logic [15:0] frame_w_ff, frame_w_in;
   logic        prog_ff, prog_in;
   status_type  pending_ff, pending_in;

   // Result register.
   logic        rsp_valid_ff;
   status_type  rsp_status_ff, rsp_status_in;
   logic [15:0] rsp_width_ff, rsp_width_in;
   logic [15:0] rsp_height_ff, rsp_height_in;

   logic        out_free, parse_go, req_take, emit;
   status_type  outcome;

   // The result register can take a new result when it is empty or draining.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign parse_go  = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_width  = rsp_width_ff;
   assign rsp_height = rsp_height_ff;

   // Per-byte parser step, applied to the byte in the input register.
   always_comb begin
      phase_in      = phase_ff;
      bytes_seen_in = bytes_seen_ff;
      marker_in     = marker_ff;
      seg_len_in    = seg_len_ff;
      seg_off_in    = seg_off_ff;
      frame_h_in    = frame_h_ff;
      frame_w_in    = frame_w_ff;
      prog_in       = prog_ff;
      pending_in    = pending_ff;
      outcome       = STATUS_NONE;
      emit          = 1'b0;
      rsp_status_in = STATUS_NONE;

      if (phase_ff != PH_IGNORE) begin
         if (bytes_seen_ff < SHORT_LIMIT) begin
            bytes_seen_in = bytes_seen_ff + 3'd1;
         end

         case (phase_ff)
            PH_PEND: begin
            end
            PH_SOI0: begin
               if (in_byte_ff == MARKER_PREFIX) phase_in = PH_SOI1;
               else outcome = STATUS_NOHDR;
            end
            PH_SOI1: begin
               if (in_byte_ff == MARKER_SOI) phase_in = PH_SCAN;
               else outcome = STATUS_NOHDR;
            end
            PH_SCAN: begin
               if (in_byte_ff == MARKER_PREFIX) phase_in = PH_MARK;
            end
            PH_MARK: begin
               if (in_byte_ff == MARKER_PREFIX) begin
                  // Fill byte: stay.
               end else if (in_byte_ff == MARKER_TEM ||
                            (in_byte_ff >= MARKER_RST_LO &&
                             in_byte_ff <= MARKER_RST_HI)) begin
                  phase_in = PH_SCAN;
               end else begin
                  marker_in = in_byte_ff;
                  phase_in  = PH_LENH;
               end
            end
            PH_LENH: begin
               seg_len_in = {in_byte_ff, 8'h00};
               phase_in   = PH_LENL;
            end
            PH_LENL: begin
               seg_len_in = {seg_len_ff[15:8], seg_len_ff[7:0] | in_byte_ff};
               seg_off_in = SEG_LEN_MIN;
               if (seg_len_in < SEG_LEN_MIN) begin
                  outcome = STATUS_NOHDR;
               end else if (is_frame_marker(marker_ff)) begin
                  if (seg_len_in < SOF_LEN_MIN) begin
                     outcome = STATUS_NOHDR;
                  end else begin
                     prog_in  = is_progressive(marker_ff);
                     phase_in = PH_BODY;
                  end
               end else if (marker_ff == MARKER_SOS) begin
                  outcome = STATUS_NOHDR;
               end else if (seg_len_in == SEG_LEN_MIN) begin
                  phase_in = PH_SCAN;
               end else begin
                  phase_in = PH_BODY;
               end
            end
            PH_BODY: begin
               if (is_frame_marker(marker_ff)) begin
                  case (seg_off_ff)
                     16'd3:   frame_h_in = {in_byte_ff, 8'h00};
                     16'd4:   frame_h_in = {frame_h_ff[15:8],
                                            frame_h_ff[7:0] | in_byte_ff};
                     16'd5:   frame_w_in = {in_byte_ff, 8'h00};
                     16'd6:   frame_w_in = {frame_w_ff[15:8],
                                            frame_w_ff[7:0] | in_byte_ff};
                     default: begin
                     end
                  endcase
               end
               seg_off_in = seg_off_ff + 16'd1;
               if (seg_off_in == seg_len_ff) begin
                  if (is_frame_marker(marker_ff)) begin
                     if (prog_ff) begin
                        outcome = STATUS_PROG;
                     end else if (frame_w_in == 16'd0 || frame_h_in == 16'd0 ||
                                  frame_w_in > max_width_ff ||
                                  frame_h_in > max_height_ff) begin
                        outcome = STATUS_BIG;
                     end else begin
                        outcome = STATUS_OK;
                     end
                  end else begin
                     phase_in = PH_SCAN;
                  end
               end
            end
            default: outcome = STATUS_NOHDR;
         endcase

         // A failure inside the first three bytes is held back: the stream may
         // still turn out too short.
         if (phase_ff == PH_PEND) begin
            if (bytes_seen_in[2]) begin
               emit = 1'b1;
               rsp_status_in = pending_ff;
            end else if (in_last_ff) begin
               emit = 1'b1;
               rsp_status_in = STATUS_SHORT;
            end
         end else if (outcome == STATUS_NOHDR && !bytes_seen_in[2]) begin
            if (in_last_ff) begin
               emit = 1'b1;
               rsp_status_in = STATUS_SHORT;
            end else begin
               pending_in = STATUS_NOHDR;
               phase_in   = PH_PEND;
            end
         end else if (outcome != STATUS_NONE) begin
            emit = 1'b1;
            rsp_status_in = outcome;
         end else if (in_last_ff) begin
            emit = 1'b1;
            rsp_status_in = bytes_seen_in[2] ? STATUS_NOHDR : STATUS_SHORT;
         end

         if (emit && !in_last_ff) begin
            phase_in = PH_IGNORE;
         end
      end

      rsp_width_in  = (rsp_status_in == STATUS_OK) ? frame_w_in : 16'd0;
      rsp_height_in = (rsp_status_in == STATUS_OK) ? frame_h_in : 16'd0;

      // The final byte of a stream always starts the next one afresh.
      if (in_last_ff && (emit || phase_ff == PH_IGNORE)) begin
         phase_in      = PH_SOI0;
         bytes_seen_in = 3'd0;
         marker_in     = 8'h00;
         seg_len_in    = 16'd0;
         seg_off_in    = 16'd0;
         frame_h_in    = 16'd0;
         frame_w_in    = 16'd0;
         prog_in       = 1'b0;
         pending_in    = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_width_ff  <= MAX_WIDTH_RESET;
         max_height_ff <= MAX_HEIGHT_RESET;
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         phase_ff      <= PH_SOI0;
         bytes_seen_ff <= 3'd0;
         marker_ff     <= 8'h00;
         seg_len_ff    <= 16'd0;
         seg_off_ff    <= 16'd0;
         frame_h_ff    <= 16'd0;
         frame_w_ff    <= 16'd0;
         prog_ff       <= 1'b0;
         pending_ff    <= STATUS_OK;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MAX_WIDTH:  max_width_ff  <= csr_wdata;
               CSR_MAX_HEIGHT: max_height_ff <= csr_wdata;
               default: begin
               end
            endcase
         end

         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (parse_go) begin
            in_valid_ff <= 1'b0;
         end

         if (out_free) begin
            rsp_valid_ff <= parse_go && emit;
         end

         if (parse_go) begin
            phase_ff      <= phase_in;
            bytes_seen_ff <= bytes_seen_in;
            marker_ff     <= marker_in;
            seg_len_ff    <= seg_len_in;
            seg_off_ff    <= seg_off_in;
            frame_h_ff    <= frame_h_in;
            frame_w_ff    <= frame_w_in;
            prog_ff       <= prog_in;
            pending_ff    <= pending_in;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
      if (parse_go && emit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_width_ff  <= rsp_width_in;
         rsp_height_ff <= rsp_height_in;
      end
   end

   // Sizes are reported only with an ok status.
   a_size_only_when_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_width == 16'd0 && rsp_height == 16'd0)
      else $error("size reported with a failing status");

   // A held-back failure only exists while fewer than four bytes are seen.
   a_pend_short: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PEND |-> !bytes_seen_ff[2])
      else $error("pending failure kept past four bytes");

   // A result that is not on the final byte mutes the rest of the stream.
   a_ignore_after_result: assert property (@(posedge clock) disable iff (reset)
      parse_go && emit && !in_last_ff |=> phase_ff == PH_IGNORE)
      else $error("parser did not enter ignore after a result");

   // A parsed byte never overwrites a result that is still stalled.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !parse_go)
      else $error("byte parsed while result register is blocked");

endmodule
